FILE: rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, codes and the CRC-16 byte step for the request filter.
// ----------------------------------------------------------------------------
package mrf_pkg;

	localparam int CNT_W       = 9;
	localparam int TABLE_SLOTS = 8;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  FN_ERR_MASK    = 8'h80;
	localparam logic [7:0]  EXC_ILLEGAL_FN = 8'h01;
	localparam logic [7:0]  BCAST_ADDR     = 8'h00;
	localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(4);

	typedef enum logic [2:0] {
		V_DISPATCH  = 3'd0,
		V_EXCEPTION = 3'd1,
		V_SHORT     = 3'd2,
		V_BADCRC    = 3'd3,
		V_BROADCAST = 3'd4,
		V_NOTOURS   = 3'd5,
		V_TOOLONG   = 3'd6
	} verdict_t;

	typedef enum logic [2:0] {
		TX_ADDR  = 3'd0,
		TX_FUNC  = 3'd1,
		TX_CODE  = 3'd2,
		TX_CRC_L = 3'd3,
		TX_CRC_H = 3'd4
	} tx_pos_t;

	typedef enum logic [2:0] {
		CFG_ADDR_A   = 3'd0,
		CFG_ADDR_B   = 3'd1,
		CFG_HCOUNT   = 3'd2,
		CFG_PAIRS_LO = 3'd3,
		CFG_PAIRS_HI = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [2:0]  idx;
		logic [7:0]  len;
		logic [7:0]  addr;
		logic [7:0]  func;
	} frame_rec_t;

	typedef struct packed {
		logic [7:0]  addr_a;
		logic [7:0]  addr_b;
		logic [3:0]  hcount;
		logic [63:0] pairs_lo;
		logic [63:0] pairs_hi;
	} cfg_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/modbus_rtu_request_filter_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_filter_core
// Checks received request frames (CRC, length, address, handler table) and
// reports a verdict per frame, or sends an illegal-function exception.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_stall  | rx_byte, frame_end
//   out      | out_valid/ out_stall | verdict .. last (1 or 5 transfers/frame)
//   cfg      | cfg_we               | cfg_index, cfg_wdata
//
// One byte per cycle in while in_stall is low; the CRC step is combinational.
// A frame end's record passes through the record queue into the output register.
// Exception frames take five output transfers, CRC built one byte each.
// in_stall rises only while the two-entry record queue is full.
// Reset clears frame state, queue and output valid; config takes reset values.
// ----------------------------------------------------------------------------
module modbus_rtu_request_filter_core import mrf_pkg::*; #(
	parameter int MAX_HANDLERS    = 8,
	parameter int MAX_FRAME_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic [2:0]  handler_index,
	output logic [7:0]  frame_length,
	output logic [7:0]  slave_address,
	output logic [7:0]  function_code,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	cfg_t       cfg_q;
	logic       take;
	logic       push;
	logic       pop;
	logic       q_valid;
	logic       q_full;
	frame_rec_t rec_in;
	frame_rec_t rec_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_a   <= 8'd1;
			cfg_q.addr_b   <= 8'd44;
			cfg_q.hcount   <= '0;
			cfg_q.pairs_lo <= '0;
			cfg_q.pairs_hi <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADDR_A:   cfg_q.addr_a   <= cfg_wdata[7:0];
				CFG_ADDR_B:   cfg_q.addr_b   <= cfg_wdata[7:0];
				CFG_HCOUNT:   cfg_q.hcount   <= cfg_wdata[3:0];
				CFG_PAIRS_LO: cfg_q.pairs_lo <= cfg_wdata;
				CFG_PAIRS_HI: cfg_q.pairs_hi <= cfg_wdata;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	mrf_front #(
		.MAX_HANDLERS    (MAX_HANDLERS),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.cfg       (cfg_q),
		.push      (push),
		.rec       (rec_in)
	);

	mrf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (rec_in),
		.pop       (pop),
		.not_empty (q_valid),
		.full      (q_full),
		.rd_rec    (rec_out)
	);

	mrf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (q_valid),
		.rec           (rec_out),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.handler_index (handler_index),
		.frame_length  (frame_length),
		.slave_address (slave_address),
		.function_code (function_code),
		.tx_byte       (tx_byte),
		.tx_valid      (tx_valid),
		.last          (last)
	);

	a_tx_only_exc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tx_valid == (verdict == V_EXCEPTION)))
		else $error("tx_valid does not match exception verdict");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !tx_valid) |-> last)
		else $error("single-result frame without last");

	a_exc_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && tx_valid && !last) |=> (out_valid && tx_valid))
		else $error("exception response broken between bytes");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && in_stall) |-> 1'b0)
		else $error("push into full queue");

endmodule

FILE: rtl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// Byte intake: running CRC, count and header capture; classifies the frame
// on its last byte and pushes one record to the queue.
// ----------------------------------------------------------------------------
module mrf_front import mrf_pkg::*; #(
	parameter int MAX_HANDLERS    = 8,
	parameter int MAX_FRAME_BYTES = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	input  cfg_t       cfg,
	output logic       push,
	output frame_rec_t rec
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);
	localparam logic [3:0]       MAX_H   = 4'(MAX_HANDLERS);

	logic [15:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       addr_q;
	logic [7:0]       func_q;

	logic [15:0]      crc_n;
	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       addr_n;
	logic [7:0]       func_n;
	logic [3:0]       n_used;
	logic [15:0]      key;
	logic [15:0]      entry;
	logic [TABLE_SLOTS-1:0] hits;
	logic [2:0]       hit_idx;
	logic [127:0]     pairs;

	always_comb begin
		addr_n = (cnt_q == '0) ? rx_byte : addr_q;
		func_n = (cnt_q == CNT_W'(1)) ? rx_byte : func_q;
		crc_n  = crc_step(crc_q, rx_byte);
		cnt_n  = (cnt_q <= MAX_CNT) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_comb begin
		pairs  = {cfg.pairs_hi, cfg.pairs_lo};
		n_used = (cfg.hcount > MAX_H) ? MAX_H : cfg.hcount;
		key    = {addr_n, func_n};
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			entry   = pairs[i*16 +: 16];
			hits[i] = (4'(i) < n_used) && (entry == key);
		end
		hit_idx = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (hits[i]) begin
				hit_idx = 3'(i);
			end
		end
	end

	always_comb begin
		rec.addr = addr_n;
		rec.func = func_n;
		rec.len  = (cnt_n > CNT_W'(255)) ? 8'hFF : cnt_n[7:0];
		rec.idx  = '0;
		priority if (cnt_n > MAX_CNT) begin
			rec.verdict = V_TOOLONG;
		end else if (cnt_n < MIN_FRAME) begin
			rec.verdict = V_SHORT;
		end else if (crc_n != 16'h0000) begin
			rec.verdict = V_BADCRC;
		end else if (addr_n == BCAST_ADDR) begin
			rec.verdict = V_BROADCAST;
		end else if (addr_n != cfg.addr_a && addr_n != cfg.addr_b) begin
			rec.verdict = V_NOTOURS;
		end else if (|hits) begin
			rec.verdict = V_DISPATCH;
			rec.idx     = hit_idx;
		end else begin
			rec.verdict = V_EXCEPTION;
		end
	end

	assign push = take && frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= '0;
			addr_q <= '0;
			func_q <= '0;
		end else if (take) begin
			if (frame_end) begin
				crc_q  <= CRC_INIT;
				cnt_q  <= '0;
				addr_q <= '0;
				func_q <= '0;
			end else begin
				crc_q  <= crc_n;
				cnt_q  <= cnt_n;
				addr_q <= addr_n;
				func_q <= func_n;
			end
		end
	end

endmodule

FILE: rtl/mrf_fifo.sv
// ----------------------------------------------------------------------------
// mrf_fifo
// Short record queue between frame intake and response output.
// ----------------------------------------------------------------------------
module mrf_fifo import mrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t wr_rec,
	input  logic       pop,
	output logic       not_empty,
	output logic       full,
	output frame_rec_t rd_rec
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	frame_rec_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_FW-1:0] fill_q;

	assign not_empty = (fill_q != '0);
	assign full      = (fill_q == CNT_FW'(FIFO_DEPTH));
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + CNT_FW'(1);
				2'b01:   fill_q <= fill_q - CNT_FW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// Result output: one item per frame, or the five-byte exception response
// whose CRC is built one byte per transfer.
// ----------------------------------------------------------------------------
module mrf_back import mrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rec_valid,
	input  frame_rec_t rec,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] verdict,
	output logic [2:0] handler_index,
	output logic [7:0] frame_length,
	output logic [7:0] slave_address,
	output logic [7:0] function_code,
	output logic [7:0] tx_byte,
	output logic       tx_valid,
	output logic       last
);

	logic        valid_q;
	frame_rec_t  cur_q;
	logic [7:0]  tx_q;
	logic        txv_q;
	logic        last_q;
	logic        seq_q;
	tx_pos_t     pos_q;
	logic [15:0] crc_q;

	logic        advance;
	logic [7:0]  seq_byte;

	assign advance = !valid_q || !out_stall;
	assign pop     = advance && !seq_q && rec_valid;

	always_comb begin
		unique case (pos_q)
			TX_ADDR:  seq_byte = cur_q.addr;
			TX_FUNC:  seq_byte = cur_q.func | FN_ERR_MASK;
			TX_CODE:  seq_byte = EXC_ILLEGAL_FN;
			TX_CRC_L: seq_byte = crc_q[7:0];
			TX_CRC_H: seq_byte = crc_q[15:8];
			default:  seq_byte = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rec;
			if (rec.verdict == V_EXCEPTION) begin
				tx_q   <= rec.addr;
				txv_q  <= 1'b1;
				last_q <= 1'b0;
				crc_q  <= crc_step(CRC_INIT, rec.addr);
			end else begin
				tx_q   <= '0;
				txv_q  <= 1'b0;
				last_q <= 1'b1;
			end
		end else if (advance && seq_q) begin
			tx_q   <= seq_byte;
			txv_q  <= 1'b1;
			last_q <= (pos_q == TX_CRC_H);
			if (pos_q == TX_FUNC || pos_q == TX_CODE) begin
				crc_q <= crc_step(crc_q, seq_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seq_q   <= 1'b0;
			pos_q   <= TX_ADDR;
		end else if (advance) begin
			if (seq_q) begin
				valid_q <= 1'b1;
				if (pos_q == TX_CRC_H) begin
					seq_q <= 1'b0;
					pos_q <= TX_ADDR;
				end else begin
					pos_q <= tx_pos_t'(pos_q + 3'd1);
				end
			end else if (rec_valid) begin
				valid_q <= 1'b1;
				if (rec.verdict == V_EXCEPTION) begin
					seq_q <= 1'b1;
					pos_q <= TX_FUNC;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_q;
	assign verdict       = cur_q.verdict;
	assign handler_index = cur_q.idx;
	assign frame_length  = cur_q.len;
	assign slave_address = cur_q.addr;
	assign function_code = cur_q.func;
	assign tx_byte       = tx_q;
	assign tx_valid      = txv_q;
	assign last          = last_q;

endmodule
